[hdl/wsdb_pkg.sv]
// ----------------------------------------------------------------------------
// wsdb_pkg
// Shared types and constants for the work-stealing deque bank.
// ----------------------------------------------------------------------------
package wsdb_pkg;

  localparam int HandleW = 32;
  localparam int WorkerW = 2;
  localparam int CfgW    = 3;

  localparam logic [CfgW-1:0] ActiveReset = 3'd4;

  typedef enum logic {
    ActPush  = 1'b0,
    ActFetch = 1'b1
  } action_e;

  typedef logic [HandleW-1:0] handle_t;

endpackage

[hdl/work_stealing_deque_bank.sv]
// ----------------------------------------------------------------------------
// work_stealing_deque_bank
// Bank of per-worker circular task deques with push, own pop and steal.
// ----------------------------------------------------------------------------
// Timing: a command is taken when start is high and busy is low. Its single
// result is on done_o for exactly one cycle, the first cycle in which busy is
// low again, and must be taken then. A push holds busy only through the check
// state. A pop from the worker's own deque passes through the pointer check,
// then the registered memory read. A fetch that must steal walks the deques
// one per cycle through the single pointer adder, starting at deque 0: when
// deque k is the one stolen from, busy covers the check, k deques stepped past,
// the hit and the read; a fetch that finds nothing ends after the check, the
// min(active_workers, NUM_WORKERS) scanned deques and a final bound test.
// Configuration writes are always ready and belong between commands.
module work_stealing_deque_bank
  import wsdb_pkg::*;
#(
  parameter int NUM_WORKERS = 4,
  parameter int DEPTH       = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               action_i,
  input  logic [WorkerW-1:0] worker_i,
  input  logic [HandleW-1:0] task_handle_i,
  output logic               done_o,
  output logic               found_o,
  output logic [HandleW-1:0] task_out_o,
  output logic [WorkerW-1:0] source_worker_o,
  output logic               stolen_o,
  output logic               overflow_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int WW    = $clog2(NUM_WORKERS);
  localparam int IdxW  = $clog2(NUM_WORKERS + 1);
  localparam int ScanW = (IdxW > CfgW) ? IdxW : CfgW;
  localparam int SlotW = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int SumW  = CntW + 1;
  localparam int AddrW = WW + SlotW;

  localparam logic [ScanW-1:0] NumLim   = ScanW'(NUM_WORKERS);
  localparam logic [CntW-1:0]  CntFull  = CntW'(DEPTH);
  localparam logic [SumW-1:0]  SumDepth = SumW'(DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_READ  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [ScanW-1:0] idx_q, idx_d;
  logic [ScanW-1:0] worker_q;
  action_e          action_q;
  handle_t          handle_q;
  logic [CfgW-1:0]  active_q;
  logic             done_q, done_d;

  logic [SlotW-1:0] front_q [NUM_WORKERS];
  logic [CntW-1:0]  count_q [NUM_WORKERS];

  logic             found_q, found_d;
  logic             stolen_q, stolen_d;
  logic             ovf_q, ovf_d;
  logic [WorkerW-1:0] src_q, src_d;
  handle_t          task_q, task_d;

  logic [SlotW-1:0] cur_front;
  logic [CntW-1:0]  cur_cnt;
  logic [CntW-1:0]  cnt_dec;
  logic [CntW-1:0]  add_b;
  logic [SumW-1:0]  sum;
  logic [SlotW-1:0] slot;
  logic [ScanW-1:0] scan_lim;
  logic [ScanW-1:0] worker_ext;

  logic             front_we, cnt_we;
  logic [SlotW-1:0] front_new;
  logic [CntW-1:0]  cnt_new;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_addr;
  handle_t          mem_rdata;

  assign cur_front  = front_q[idx_q[WW-1:0]];
  assign cur_cnt    = count_q[idx_q[WW-1:0]];
  assign cnt_dec    = cur_cnt - CntW'(1);
  assign worker_ext = ScanW'(worker_i);
  assign scan_lim   = (ScanW'(active_q) > NumLim) ? NumLim : ScanW'(active_q);

  // shared pointer unit: front plus offset, wrapped into the ring
  assign sum  = SumW'(cur_front) + SumW'(add_b);
  assign slot = (sum >= SumDepth) ? SlotW'(sum - SumDepth) : SlotW'(sum);

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    done_d    = 1'b0;
    add_b     = '0;
    front_we  = 1'b0;
    front_new = slot;
    cnt_we    = 1'b0;
    cnt_new   = cnt_dec;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = {idx_q[WW-1:0], slot};
    found_d   = found_q;
    stolen_d  = stolen_q;
    ovf_d     = ovf_q;
    src_d     = src_q;
    task_d    = task_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          idx_d   = worker_ext;
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        found_d  = 1'b0;
        stolen_d = 1'b0;
        ovf_d    = 1'b0;
        src_d    = '0;
        task_d   = '0;
        if (worker_q >= NumLim) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (action_q == ActPush) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (cur_cnt == CntFull) begin
            ovf_d = 1'b1;
          end else begin
            add_b   = cur_cnt;
            mem_we  = 1'b1;
            cnt_we  = 1'b1;
            cnt_new = cur_cnt + CntW'(1);
          end
        end else if (cur_cnt != '0) begin
          // pop from the back of the own deque
          add_b   = cnt_dec;
          mem_re  = 1'b1;
          cnt_we  = 1'b1;
          found_d = 1'b1;
          src_d   = WorkerW'(worker_q);
          state_d = S_READ;
        end else begin
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        if (idx_q >= scan_lim) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (idx_q == worker_q || cur_cnt == '0) begin
          idx_d = idx_q + ScanW'(1);
        end else begin
          // steal from the front and advance it
          add_b    = CntW'(1);
          mem_addr = {idx_q[WW-1:0], cur_front};
          mem_re   = 1'b1;
          front_we = 1'b1;
          cnt_we   = 1'b1;
          found_d  = 1'b1;
          stolen_d = 1'b1;
          src_d    = WorkerW'(idx_q);
          state_d  = S_READ;
        end
      end

      S_READ: begin
        task_d  = mem_rdata;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      done_q   <= 1'b0;
      active_q <= ActiveReset;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_WORKERS; k++) begin
        front_q[k] <= '0;
        count_q[k] <= '0;
      end
    end else begin
      if (front_we) begin
        front_q[idx_q[WW-1:0]] <= front_new;
      end
      if (cnt_we) begin
        count_q[idx_q[WW-1:0]] <= cnt_new;
      end
    end
  end

  // transaction capture and result payload
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      worker_q <= worker_ext;
      action_q <= action_e'(action_i);
      handle_q <= task_handle_i;
    end
    found_q  <= found_d;
    stolen_q <= stolen_d;
    ovf_q    <= ovf_d;
    src_q    <= src_d;
    task_q   <= task_d;
  end

  wsdb_store #(
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (handle_q),
    .rdata_o (mem_rdata)
  );

  assign done_o          = done_q;
  assign found_o         = found_q;
  assign task_out_o      = task_q;
  assign source_worker_o = src_q;
  assign stolen_o        = stolen_q;
  assign overflow_o      = ovf_q;

endmodule

[hdl/wsdb_store.sv]
// ----------------------------------------------------------------------------
// wsdb_store
// Single-port handle memory with a registered read port.
// ----------------------------------------------------------------------------
module wsdb_store
  import wsdb_pkg::*;
#(
  parameter int AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  handle_t          wdata_i,
  output handle_t          rdata_o
);

  handle_t mem_q [2**AddrW];
  handle_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[test/work_stealing_deque_bank_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// work_stealing_deque_bank_test
// Self-checking bench for the deque bank. A shadow copy of every deque predicts
// each push or fetch outcome, including own pops, steals, empty fetches and
// dropped pushes. Directed cases are followed by random traffic under all
// active_workers settings, with random gaps on the command side.
// ----------------------------------------------------------------------------
module work_stealing_deque_bank_test;
  import wsdb_pkg::*;

  localparam int NumWorkers = 4;
  localparam int Depth      = 256;
  localparam int MaxReports = 10;

  typedef logic [WorkerW-1:0] worker_t;

  typedef struct packed {
    logic    found;
    handle_t task_h;
    worker_t source;
    logic    stolen;
    logic    overflow;
  } outcome_t;

  // shadow deques and the queue of outcomes still owed by the block
  class deque_ledger;
    handle_t     slots [NumWorkers][Depth];
    int unsigned head [NumWorkers];
    int unsigned fill [NumWorkers];
    int unsigned active;
    outcome_t    outcome_q [$];
    int unsigned mismatches, pushes, drops, own_pops, steals, misses, cfg_writes;

    function new();
      active = ActiveReset;
      foreach (head[i]) begin
        head[i] = 0;
        fill[i] = 0;
      end
    endfunction

    function void set_active(logic [CfgW-1:0] value);
      active = value;
      cfg_writes++;
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction

    function void take_command(action_e act, worker_t w, handle_t h);
      outcome_t    o;
      int unsigned scan;
      int unsigned slot;
      o = '0;
      if (w >= NumWorkers) begin
        outcome_q.push_back(o);
        return;
      end
      if (act == ActPush) begin
        if (fill[w] >= Depth) begin
          o.overflow = 1'b1;
          drops++;
        end else begin
          slots[w][(head[w] + fill[w]) % Depth] = h;
          fill[w]++;
          pushes++;
        end
      end else if (fill[w] > 0) begin
        slot = (head[w] + fill[w] - 1) % Depth;
        fill[w]--;
        o.found  = 1'b1;
        o.task_h = slots[w][slot];
        o.source = w;
        own_pops++;
      end else begin
        scan = (active < NumWorkers) ? active : NumWorkers;
        for (int unsigned i = 0; i < scan; i++) begin
          if (i != w && fill[i] != 0) begin
            o.found  = 1'b1;
            o.task_h = slots[i][head[i]];
            o.source = worker_t'(i);
            o.stolen = 1'b1;
            head[i]  = (head[i] + 1) % Depth;
            fill[i]--;
            break;
          end
        end
        if (o.found) steals++;
        else misses++;
      end
      outcome_q.push_back(o);
    endfunction

    function void compare_result(outcome_t got);
      outcome_t exp;
      string    bad;
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: result with nothing outstanding: found=%0b task=%h src=%0d stl=%0b ovf=%0b",
                   $realtime, got.found, got.task_h, got.source, got.stolen, got.overflow);
        return;
      end
      exp = outcome_q.pop_front();
      bad = "";
      if (got.found !== exp.found) bad = {bad, " found"};
      if (got.task_h !== exp.task_h) bad = {bad, " task_out"};
      if (got.source !== exp.source) bad = {bad, " source_worker"};
      if (got.stolen !== exp.stolen) bad = {bad, " stolen"};
      if (got.overflow !== exp.overflow) bad = {bad, " overflow"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: mismatch on%s: exp found=%0b task=%h src=%0d stl=%0b ovf=%0b, got found=%0b task=%h src=%0d stl=%0b ovf=%0b",
                   $realtime, bad, exp.found, exp.task_h, exp.source, exp.stolen, exp.overflow,
                   got.found, got.task_h, got.source, got.stolen, got.overflow);
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             action_i = 1'b0;
  worker_t          worker_i = '0;
  handle_t          task_handle_i = '0;
  logic             done_o;
  logic             found_o;
  handle_t          task_out_o;
  worker_t          source_worker_o;
  logic             stolen_o;
  logic             overflow_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CfgW-1:0]  cfg_data_i = '0;

  deque_ledger ledger;
  bit          gaps_on;
  int unsigned issued;

  work_stealing_deque_bank #(
    .NUM_WORKERS(NumWorkers),
    .DEPTH      (Depth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .worker_i       (worker_i),
    .task_handle_i  (task_handle_i),
    .done_o         (done_o),
    .found_o        (found_o),
    .task_out_o     (task_out_o),
    .source_worker_o(source_worker_o),
    .stolen_o       (stolen_o),
    .overflow_o     (overflow_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // results are checked before the same edge's transaction is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        ledger.compare_result({found_o, task_out_o, source_worker_o, stolen_o, overflow_o});
      if (start && !busy)
        ledger.take_command(action_e'(action_i), worker_i, task_handle_i);
      if (cfg_valid_i && cfg_ready_o)
        ledger.set_active(cfg_data_i);
    end
  end

  task automatic issue(action_e act, worker_t w, handle_t h);
    if (gaps_on && $urandom_range(99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    start         <= 1'b1;
    action_i      <= act;
    worker_i      <= w;
    task_handle_i <= h;
    do @(posedge clk_i); while (busy);
    issued++;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_active(logic [CfgW-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic handle_t pick_handle();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return handle_t'($urandom);
    endcase
  endfunction

  // fill one deque to the brim, then a few pushes that must be dropped
  task automatic flood(worker_t w);
    while (ledger.fill[w] < Depth) issue(ActPush, w, pick_handle());
    repeat ($urandom_range(1, 3)) issue(ActPush, w, pick_handle());
  endtask

  task automatic random_traffic(int unsigned count);
    int unsigned push_pct;
    push_pct = $urandom_range(35, 65);
    repeat (count) begin
      if ($urandom_range(99) < push_pct)
        issue(ActPush, worker_t'($urandom_range(NumWorkers - 1)), pick_handle());
      else
        issue(ActFetch, worker_t'($urandom_range(NumWorkers - 1)), pick_handle());
    end
  endtask

  initial begin
    logic [CfgW-1:0] settings [10];
    settings = '{3'd4, 3'd3, 3'd7, 3'd2, 3'd0, 3'd1, 3'd5, 3'd6, 3'd4, 3'd3};
    ledger  = new();
    gaps_on = 1'b1;
    issued  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting, all four deques scanned
    issue(ActFetch, 2'd0, 32'hFFFF_FFFF);
    issue(ActPush, 2'd0, 32'h0000_0000);
    issue(ActPush, 2'd1, 32'hFFFF_FFFF);
    issue(ActPush, 2'd1, 32'hA5A5_A5A5);
    issue(ActPush, 2'd1, 32'h5A5A_5A5A);
    issue(ActFetch, 2'd1, 32'h0);
    issue(ActFetch, 2'd0, 32'h0);
    issue(ActFetch, 2'd0, 32'h0);
    issue(ActFetch, 2'd3, 32'h0);
    issue(ActPush, 2'd3, 32'h1234_5678);
    issue(ActFetch, 2'd2, 32'h0);
    issue(ActFetch, 2'd2, 32'h0);

    // two active workers: deques 2 and 3 are private
    write_active(3'd2);
    issue(ActPush, 2'd3, 32'hDEAD_BEEF);
    issue(ActPush, 2'd2, 32'hCAFE_F00D);
    issue(ActFetch, 2'd0, 32'h0);
    issue(ActFetch, 2'd3, 32'h0);
    issue(ActPush, 2'd1, 32'h0000_0001);
    issue(ActFetch, 2'd3, 32'h0);
    issue(ActFetch, 2'd2, 32'h0);
    issue(ActPush, 2'd0, 32'h8000_0000);
    issue(ActFetch, 2'd1, 32'h0);
    issue(ActFetch, 2'd0, 32'h0);

    foreach (settings[p]) begin
      write_active(settings[p]);
      gaps_on = (p != 3);
      if (p == 2 || p == 6) flood(worker_t'($urandom_range(NumWorkers - 1)));
      random_traffic(150);
    end

    settle();
    $display("run covered %0d commands over %0d register writes", issued, ledger.cfg_writes);
    $display("pushes %0d, dropped %0d, own pops %0d, steals %0d, empty fetches %0d",
             ledger.pushes, ledger.drops, ledger.own_pops, ledger.steals, ledger.misses);
    if (ledger.pending() != 0)
      $display("%0d results never arrived", ledger.pending());
    if (ledger.mismatches != 0)
      $display("%0d mismatches in total", ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting on the block");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
hdl/wsdb_pkg.sv
hdl/wsdb_store.sv
hdl/work_stealing_deque_bank.sv
test/work_stealing_deque_bank_test.sv
